// ===== sv/gbfs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbfs_pkg: shared codes for the graph search engine
// Graph sizes, command kinds and status codes.
// ----------------------------------------------------------------------------
package gbfs_pkg;
    typedef logic [2:0] t_kind;
    typedef logic [2:0] t_status;

    // graph sizes, fixed by the 4-bit vertex fields
    localparam int VERTICES         = 16;
    localparam int EDGES_PER_VERTEX = 16;

    localparam t_kind KIND_CLEAR = 3'd0;
    localparam t_kind KIND_ADD_V = 3'd1;
    localparam t_kind KIND_ADD_E = 3'd2;
    localparam t_kind KIND_DFS   = 3'd3;
    localparam t_kind KIND_BFS   = 3'd4;

    localparam t_status ST_OK    = 3'd0;
    localparam t_status ST_VOVF  = 3'd1;
    localparam t_status ST_INDEX = 3'd2;
    localparam t_status ST_SAME  = 3'd3;
    localparam t_status ST_FULL  = 3'd4;
endpackage
`default_nettype wire

// ===== sv/graph_bfs_dfs_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// graph_bfs_dfs_engine: directed graph store with DFS / BFS walk
// Edge lists live in one synchronous memory; a sequencer walks them.
// ----------------------------------------------------------------------------
// One command word is taken at a time. Clear, add vertex and add edge return
// one status word on the cycle after the command is taken. A search returns
// the visited vertices in order, the final one flagged by o_last; for each
// stored edge it walks it puts out the address, then takes the memory data,
// and each visited vertex adds an output handoff and a stack pop or queue
// step; the edge memory has a single read port. A new command is taken
// once the last word of the previous one has been handed over.
module graph_bfs_dfs_engine (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_ready,
    input  wire  [2:0] i_kind,
    input  wire  [3:0] i_edge_from,
    input  wire  [3:0] i_vertex,
    output logic       o_valid,
    input  wire        i_ready,
    output logic [2:0] o_status,
    output logic [3:0] o_visited_vertex,
    output logic       o_last
);
    localparam int VERTICES         = gbfs_pkg::VERTICES;
    localparam int EDGES_PER_VERTEX = gbfs_pkg::EDGES_PER_VERTEX;
    localparam int VW = (VERTICES > 1) ? $clog2(VERTICES) : 1;
    localparam int EW = (EDGES_PER_VERTEX > 1) ? $clog2(EDGES_PER_VERTEX) : 1;
    localparam int CW = $clog2(EDGES_PER_VERTEX + 1);
    localparam int NW = $clog2(VERTICES + 1);
    localparam int SW = $clog2(VERTICES + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_POP  = 3'd1; // pick next edge to read
    localparam logic [2:0] S_RD   = 3'd2; // edge memory data arrives
    localparam logic [2:0] S_OUT  = 3'd3; // wait for output to drain
    localparam logic [2:0] S_FIN  = 3'd4; // flag last visit

    // state registers
    logic [2:0]      r_state;
    logic [NW-1:0]   r_vcount;
    logic [CW-1:0]   r_ecount [VERTICES];
    logic            r_vis    [VERTICES];
    logic            r_dfs;
    logic [VW-1:0]   r_u;
    logic [CW-1:0]   r_pos;
    logic [SW-1:0]   r_top, r_head, r_tail;
    logic [VW-1:0]   r_stk_v [VERTICES];
    logic [CW-1:0]   r_stk_p [VERTICES];
    logic [VW-1:0]   r_queue [VERTICES];
    logic [4:0]      r_nres;
    logic            r_hold_v;
    logic [3:0]      r_hold_w;

    // edge memory, one row per vertex
    logic [3:0] r_mem [VERTICES*EDGES_PER_VERTEX];
    logic [3:0] r_rdata;
    logic       mem_we;
    logic       mem_re;
    logic [VW+EW-1:0] mem_wa, mem_ra;

    // read data holds until the next edge read
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= i_vertex;
        if (mem_re) r_rdata <= r_mem[mem_ra];
    end

    // output register
    logic       r_ov;
    logic [2:0] r_ost;
    logic [3:0] r_ovx;
    logic       r_olast;
    assign o_valid          = r_ov;
    assign o_status         = r_ost;
    assign o_visited_vertex = r_ovx;
    assign o_last           = r_olast;
    wire out_free = !r_ov || i_ready;

    assign o_ready = (r_state == S_IDLE) && out_free;
    wire acc = i_valid && o_ready;

    wire [VW-1:0] from_i = i_edge_from[VW-1:0];
    wire [VW-1:0] v_i    = i_vertex[VW-1:0];
    wire from_ok = ({1'b0, i_edge_from} < 5'(r_vcount)) && (32'(i_edge_from) < VERTICES);
    wire v_ok    = ({1'b0, i_vertex} < 5'(r_vcount)) && (32'(i_vertex) < VERTICES);
    wire [CW-1:0] ec_from = r_ecount[from_i];

    assign mem_we = acc && i_kind == gbfs_pkg::KIND_ADD_E && i_edge_from != i_vertex
                    && from_ok && v_ok && 32'(ec_from) < EDGES_PER_VERTEX;
    assign mem_wa = {from_i, ec_from[EW-1:0]};

    // next edge selection for the walk
    wire [SW-1:0] tm1 = r_top - SW'(1);
    logic         have_edge;
    logic [VW-1:0] sel_u;
    logic [CW-1:0] sel_p;
    always_comb begin
        have_edge = 1'b0;
        sel_u = r_u;
        sel_p = r_pos;
        if (r_dfs) begin
            sel_u = r_stk_v[tm1[VW-1:0]];
            sel_p = r_stk_p[tm1[VW-1:0]] - CW'(1);
            have_edge = r_top != '0 && r_stk_p[tm1[VW-1:0]] != '0;
        end else begin
            have_edge = r_pos != '0;
            sel_p = r_pos - CW'(1);
        end
    end
    assign mem_ra = {sel_u, sel_p[EW-1:0]};
    assign mem_re = (r_state == S_POP) && have_edge;

    wire [VW-1:0] w  = r_rdata[VW-1:0];
    wire w_new = (32'(r_rdata) < VERTICES) && !r_vis[w];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_vcount <= '0;
            r_ov     <= 1'b0;
            r_hold_v <= 1'b0;
            for (int i = 0; i < VERTICES; i++) begin
                r_ecount[i] <= '0;
                r_vis[i]    <= 1'b0;
            end
        end else begin
            if (r_ov && i_ready) r_ov <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_ovx   <= '0;
                        r_olast <= 1'b1;
                        r_ost   <= gbfs_pkg::ST_OK;
                        r_ov    <= 1'b1;
                        case (i_kind)
                            gbfs_pkg::KIND_CLEAR: begin
                                r_vcount <= '0;
                                for (int i = 0; i < VERTICES; i++) begin
                                    r_ecount[i] <= '0;
                                    r_vis[i]    <= 1'b0;
                                end
                            end
                            gbfs_pkg::KIND_ADD_V: begin
                                if (32'(r_vcount) >= VERTICES) r_ost <= gbfs_pkg::ST_VOVF;
                                else r_vcount <= r_vcount + NW'(1);
                            end
                            gbfs_pkg::KIND_ADD_E: begin
                                if (i_edge_from == i_vertex) r_ost <= gbfs_pkg::ST_SAME;
                                else if (!from_ok || !v_ok) r_ost <= gbfs_pkg::ST_INDEX;
                                else if (32'(ec_from) >= EDGES_PER_VERTEX)
                                    r_ost <= gbfs_pkg::ST_FULL;
                                else r_ecount[from_i] <= ec_from + CW'(1);
                            end
                            gbfs_pkg::KIND_DFS, gbfs_pkg::KIND_BFS: begin
                                if (!v_ok) begin
                                    r_ost <= gbfs_pkg::ST_INDEX;
                                end else begin
                                    // start: emit start vertex into hold slot
                                    r_ov     <= 1'b0;
                                    r_hold_v <= 1'b1;
                                    r_hold_w <= i_vertex;
                                    r_nres   <= 5'd1;
                                    for (int i = 0; i < VERTICES; i++)
                                        r_vis[i] <= (i == 32'(v_i));
                                    r_dfs      <= (i_kind == gbfs_pkg::KIND_DFS);
                                    r_stk_v[0] <= v_i;
                                    r_stk_p[0] <= r_ecount[v_i];
                                    r_top      <= SW'(1);
                                    r_u        <= v_i;
                                    r_pos      <= r_ecount[v_i];
                                    r_queue[0] <= v_i;
                                    r_head     <= SW'(1);
                                    r_tail     <= SW'(1);
                                    r_state    <= S_POP;
                                end
                            end
                            default: r_ov <= 1'b0;
                        endcase
                    end
                end
                S_POP: begin
                    if (have_edge) begin
                        if (r_dfs) r_stk_p[tm1[VW-1:0]] <= sel_p;
                        else r_pos <= sel_p;
                        r_state <= S_RD;
                    end else if (r_dfs && r_top != '0) begin
                        r_top <= tm1;
                    end else if (!r_dfs && r_head < r_tail) begin
                        r_u    <= r_queue[r_head[VW-1:0]];
                        r_pos  <= r_ecount[r_queue[r_head[VW-1:0]]];
                        r_head <= r_head + SW'(1);
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_RD: begin
                    if (w_new) begin
                        r_vis[w] <= 1'b1;
                        if (r_dfs) begin
                            if (32'(r_top) < VERTICES) begin
                                r_stk_v[r_top[VW-1:0]] <= w;
                                r_stk_p[r_top[VW-1:0]] <= r_ecount[w];
                                r_top <= r_top + SW'(1);
                            end
                        end else if (32'(r_tail) < VERTICES) begin
                            r_queue[r_tail[VW-1:0]] <= w;
                            r_tail <= r_tail + SW'(1);
                        end
                        if (r_nres < 5'd16) begin
                            r_nres <= r_nres + 5'd1;
                            // hand previous held visit to output
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_POP;
                        end
                    end else begin
                        r_state <= S_POP;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_ov     <= 1'b1;
                        r_ost    <= gbfs_pkg::ST_OK;
                        r_ovx    <= r_hold_w;
                        r_olast  <= 1'b0;
                        r_hold_w <= r_rdata;
                        r_state  <= S_POP;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_ov     <= 1'b1;
                        r_ost    <= gbfs_pkg::ST_OK;
                        r_ovx    <= r_hold_w;
                        r_olast  <= 1'b1;
                        r_hold_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // checks
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_hold_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP || r_state == S_RD) |-> r_hold_v) else $error("hold lost");
    a_nres_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nres <= 5'd16 || !r_hold_v) else $error("too many visits");
    a_status_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != gbfs_pkg::ST_OK) |-> (o_last && o_visited_vertex == 4'd0))
        else $error("bad status word");
endmodule
`default_nettype wire

// ===== sim/graph_bfs_dfs_engine_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_bfs_dfs_engine_tb: self-checking bench for the graph search engine
// Drives command words through a directed table and then random traffic,
// predicts status and visit words with a software graph model, and compares
// every returned word in order.
// ----------------------------------------------------------------------------
module graph_bfs_dfs_engine_tb;

    localparam int NV = 16;
    localparam int NE = 16;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] vtx;
        logic       last;
    } t_word;

    typedef struct {
        logic [2:0] kind;
        logic [3:0] from;
        logic [3:0] vtx;
        bit         typed;
        t_word      want;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [2:0] i_kind = '0;
    logic [3:0] i_edge_from = '0;
    logic [3:0] i_vertex = '0;
    logic       i_ready = 1'b0;
    wire        o_ready, o_valid, o_last;
    wire  [2:0] o_status;
    wire  [3:0] o_visited_vertex;

    graph_bfs_dfs_engine u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_kind(i_kind), .i_edge_from(i_edge_from), .i_vertex(i_vertex),
        .o_valid(o_valid), .i_ready(i_ready), .o_status(o_status),
        .o_visited_vertex(o_visited_vertex), .o_last(o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // graph model state
    int         g_nvert;
    logic [3:0] g_adj [NV][NE];
    int         g_deg [NV];
    bit         g_seen [NV];

    t_word      want_q [$];
    int         errors = 0;
    int         idle_cycles = 0;
    bit         hold_off = 0;
    bit         sink_hold_req = 0;

    function automatic t_word mk(logic [2:0] st, logic [3:0] v, logic l);
        t_word w;
        w.status = st; w.vtx = v; w.last = l;
        return w;
    endfunction

    // visit word for a search
    task automatic visit(input int v);
        g_seen[v] = 1;
        want_q.push_back(mk(gbfs_pkg::ST_OK, v[3:0], 1'b0));
    endtask

    // apply one command to the graph model, queue the words it returns
    task automatic predict_cmd(input logic [2:0] kind, input logic [3:0] from,
                               input logic [3:0] v);
        int stk_v [NV];
        int stk_p [NV];
        int fifo [NV];
        int top, head, tail, u, w, p;
        case (kind)
            gbfs_pkg::KIND_CLEAR: begin
                g_nvert = 0;
                for (int i = 0; i < NV; i++) begin g_deg[i] = 0; g_seen[i] = 0; end
                want_q.push_back(mk(gbfs_pkg::ST_OK, 4'd0, 1'b1));
            end
            gbfs_pkg::KIND_ADD_V: begin
                if (g_nvert + 1 > NV) want_q.push_back(mk(gbfs_pkg::ST_VOVF, 4'd0, 1'b1));
                else begin
                    g_nvert++;
                    want_q.push_back(mk(gbfs_pkg::ST_OK, 4'd0, 1'b1));
                end
            end
            gbfs_pkg::KIND_ADD_E: begin
                if (from == v) want_q.push_back(mk(gbfs_pkg::ST_SAME, 4'd0, 1'b1));
                else if (from >= g_nvert || v >= g_nvert)
                    want_q.push_back(mk(gbfs_pkg::ST_INDEX, 4'd0, 1'b1));
                else if (g_deg[from] >= NE)
                    want_q.push_back(mk(gbfs_pkg::ST_FULL, 4'd0, 1'b1));
                else begin
                    g_adj[from][g_deg[from]] = v;
                    g_deg[from]++;
                    want_q.push_back(mk(gbfs_pkg::ST_OK, 4'd0, 1'b1));
                end
            end
            gbfs_pkg::KIND_DFS, gbfs_pkg::KIND_BFS: begin
                if (v >= g_nvert) want_q.push_back(mk(gbfs_pkg::ST_INDEX, 4'd0, 1'b1));
                else begin
                    for (int i = 0; i < NV; i++) g_seen[i] = 0;
                    visit(v);
                    if (kind == gbfs_pkg::KIND_DFS) begin
                        stk_v[0] = v; stk_p[0] = g_deg[v]; top = 1;
                        while (top > 0) begin
                            u = stk_v[top-1];
                            if (stk_p[top-1] == 0) top--;
                            else begin
                                stk_p[top-1]--;
                                w = g_adj[u][stk_p[top-1]];
                                if (!g_seen[w]) begin
                                    visit(w);
                                    if (top < NV) begin
                                        stk_v[top] = w; stk_p[top] = g_deg[w]; top++;
                                    end
                                end
                            end
                        end
                    end else begin
                        head = 0; tail = 0;
                        fifo[tail++] = v;
                        while (head < tail) begin
                            u = fifo[head++];
                            p = g_deg[u];
                            while (p > 0) begin
                                p--;
                                w = g_adj[u][p];
                                if (!g_seen[w]) begin
                                    visit(w);
                                    if (tail < NV) fifo[tail++] = w;
                                end
                            end
                        end
                    end
                    want_q[want_q.size()-1].last = 1'b1;
                end
            end
            default: ;
        endcase
    endtask

    // offer one word and wait for acceptance; valid drops only for a gap
    task automatic send_word(input logic [2:0] kind, input logic [3:0] from,
                             input logic [3:0] v, input int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= kind; i_edge_from <= from; i_vertex <= v;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_cmd(kind, from, v);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (want_q.size() != 0) @(posedge i_clk);
    endtask

    // random command, mostly well-formed graph building and searches
    task automatic rand_cmd(output logic [2:0] k, output logic [3:0] f,
                            output logic [3:0] v);
        int r, lim;
        r = $urandom_range(0, 99);
        lim = (g_nvert > 0) ? g_nvert - 1 : 0;
        f = 4'($urandom_range(0, lim));
        v = 4'($urandom_range(0, lim));
        if (r < 2)       k = gbfs_pkg::KIND_CLEAR;
        else if (r < 14) k = gbfs_pkg::KIND_ADD_V;
        else if (r < 60) k = gbfs_pkg::KIND_ADD_E;
        else if (r < 72) k = gbfs_pkg::KIND_DFS;
        else if (r < 84) k = gbfs_pkg::KIND_BFS;
        else begin
            k = 3'($urandom_range(0, 7));
            f = 4'($urandom); v = 4'($urandom);
        end
    endtask

    // result sink: random stalls plus one long hold-off
    initial begin : sink
        int wait_n;
        t_word got, exp_w;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (sink_hold_req) begin
                i_ready <= 1'b0;
                hold_off = 1;
                repeat (400) @(negedge i_clk);
                sink_hold_req = 0;
                hold_off = 0;
            end
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if ($urandom_range(0, 4) == 0) wait_n = 0;
            if (wait_n > 0) begin
                i_ready <= 1'b0;
                repeat (wait_n) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            got = {o_status, o_visited_vertex, o_last};
            if (want_q.size() == 0) begin
                $display("%0t: unexpected word status=%0d vertex=%0d last=%0d",
                         $time, got.status, got.vtx, got.last);
                errors++;
            end else begin
                exp_w = want_q.pop_front();
                if (got !== exp_w) begin
                    $display("%0t: word mismatch expected st=%0d v=%0d l=%0d actual st=%0d v=%0d l=%0d",
                             $time, exp_w.status, exp_w.vtx, exp_w.last,
                             got.status, got.vtx, got.last);
                    errors++;
                end
            end
        end
    end

    // watchdog: cycles with no accepted word on either side
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || hold_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // directed table and random traffic
    initial begin : source
        t_row rows [$];
        t_row rw;
        logic [2:0] k;
        logic [3:0] f, v;
        for (int i = 0; i < NV; i++) begin g_deg[i] = 0; g_seen[i] = 0; end
        g_nvert = 0;
        // directed rows: typed where obvious, others checked by the model
        rows.push_back('{gbfs_pkg::KIND_DFS, 4'd0, 4'd0, 1'b1,
                         mk(gbfs_pkg::ST_INDEX, 4'd0, 1'b1)});
        rows.push_back('{gbfs_pkg::KIND_ADD_E, 4'd0, 4'd1, 1'b1,
                         mk(gbfs_pkg::ST_INDEX, 4'd0, 1'b1)});
        rows.push_back('{gbfs_pkg::KIND_ADD_E, 4'd5, 4'd5, 1'b1,
                         mk(gbfs_pkg::ST_SAME, 4'd0, 1'b1)});
        rows.push_back('{gbfs_pkg::KIND_ADD_V, 4'd0, 4'd0, 1'b1,
                         mk(gbfs_pkg::ST_OK, 4'd0, 1'b1)});
        rows.push_back('{gbfs_pkg::KIND_BFS, 4'd0, 4'd0, 1'b1,
                         mk(gbfs_pkg::ST_OK, 4'd0, 1'b1)});
        rows.push_back('{3'd7, 4'd15, 4'd15, 1'b0, '0});
        rows.push_back('{3'd5, 4'd0, 4'd0, 1'b0, '0});
        for (int i = 0; i < 15; i++)
            rows.push_back('{gbfs_pkg::KIND_ADD_V, 4'd0, 4'd0, 1'b0, '0});
        rows.push_back('{gbfs_pkg::KIND_ADD_V, 4'd15, 4'd15, 1'b1,
                         mk(gbfs_pkg::ST_VOVF, 4'd0, 1'b1)});
        rows.push_back('{gbfs_pkg::KIND_ADD_E, 4'd15, 4'd0, 1'b0, '0});
        rows.push_back('{gbfs_pkg::KIND_ADD_E, 4'd0, 4'd15, 1'b0, '0});
        rows.push_back('{gbfs_pkg::KIND_DFS, 4'd0, 4'd15, 1'b0, '0});
        rows.push_back('{gbfs_pkg::KIND_BFS, 4'd0, 4'd0, 1'b0, '0});
        rows.push_back('{3'd6, 4'd10, 4'd5, 1'b0, '0});
        rows.push_back('{gbfs_pkg::KIND_CLEAR, 4'd0, 4'd0, 1'b1,
                         mk(gbfs_pkg::ST_OK, 4'd0, 1'b1)});
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (rows[i]) begin
            rw = rows[i];
            send_word(rw.kind, rw.from, rw.vtx, $urandom_range(0, 16));
            if (rw.typed && want_q[$] !== rw.want) begin
                $display("%0t: table row %0d predicted mismatch expected %h actual %h",
                         $time, i, rw.want, want_q[$]);
                errors++;
            end
        end
        // graph with a full edge list at vertex 3 and edge-list-full errors
        for (int i = 0; i < NV; i++) send_word(gbfs_pkg::KIND_ADD_V, 4'd0, 4'd0, 0);
        for (int i = 0; i < NE + 2; i++)
            send_word(gbfs_pkg::KIND_ADD_E, 4'd3, 4'($urandom_range(0, 15)), 0);
        send_word(gbfs_pkg::KIND_DFS, 4'd0, 4'd3, 0);
        send_word(gbfs_pkg::KIND_BFS, 4'd0, 4'd3, 0);
        // long receiver hold-off while commands keep coming
        sink_hold_req = 1;
        for (int i = 0; i < 8; i++)
            send_word(gbfs_pkg::KIND_ADD_E, 4'($urandom_range(0, 15)),
                      4'($urandom_range(0, 15)), 0);
        // sender pause until all words are back
        drain();
        send_word(gbfs_pkg::KIND_CLEAR, 4'd0, 4'd0, 0);
        for (int n = 0; n < 230; n++) begin
            rand_cmd(k, f, v);
            send_word(k, f, v, ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 16));
        end
        drain();
        repeat (50) @(posedge i_clk);
        if (errors == 0 && want_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
